@@ hw/rtl/b64d_pkg.sv @@
// ============================================================================
// b64d_pkg: shared types and constants for the base64 stream decoder
// Holds the alphabet lookup, the status codes and the result group record.
// ============================================================================
package b64d_pkg;

    localparam int CHAR_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int ACC_W    = 18;
    localparam int GROUP_W  = 24;
    localparam int BYTE_W   = 8;

    localparam logic [CHAR_W-1:0] PAD_CODE = 8'h3D;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_BAD_CHAR = 2'd2
    } status_t;

    // One decoded quartet (or the closing empty result) handed to the output side
    typedef struct packed {
        logic                emit;
        logic [1:0]          count;
        logic                byte_valid;
        logic [GROUP_W-1:0]  data;
        logic                fin;
        status_t             status;
    } b64d_grp_t;

    // Map a character to {in_alphabet, sextet}; the sextet is zero when not in the alphabet
    function automatic logic [SEXTET_W:0] sextet_lookup(input logic [CHAR_W-1:0] c);
        logic [SEXTET_W:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = {1'b1, SEXTET_W'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = {1'b1, SEXTET_W'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, SEXTET_W'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2B)
        begin
            r = {1'b1, SEXTET_W'(62)};
        end
        else if (c == 8'h2F)
        begin
            r = {1'b1, SEXTET_W'(63)};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/b64d_quartet.sv @@
// ============================================================================
// b64d_quartet: character decode and quartet accumulation
// Keeps the sextets of the current quartet, validates each character and
// forms the result group on the fourth or final character.
// ============================================================================
module b64d_quartet
    import b64d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              final_char,
    output logic              pos_last,
    output b64d_grp_t         grp
);

    logic [ACC_W-1:0]    accum_reg, accum_next;
    logic [1:0]          pos_reg, pos_next;
    logic                pad_reg, pad_next;
    logic                err_reg, err_next;

    logic [SEXTET_W:0]   lookup;
    logic [SEXTET_W-1:0] sextet;
    logic                is_pad;
    logic [1:0]          nbytes;

    assign lookup   = sextet_lookup(char_code);
    assign sextet   = lookup[SEXTET_W-1:0];
    assign is_pad   = (char_code == PAD_CODE);
    assign pos_last = (pos_reg == 2'd3);

    always_comb
    begin
        err_next = err_reg;
        if (is_pad)
        begin
            if (pos_reg == 2'd3)
            begin
                err_next = err_reg | ~final_char;
            end
            else if (pos_reg != 2'd2)
            begin
                err_next = 1'b1;
            end
        end
        else
        begin
            if (!lookup[SEXTET_W] || (pos_last && pad_reg))
            begin
                err_next = 1'b1;
            end
        end

        nbytes = 2'd0;
        if (pos_last && !err_next)
        begin
            nbytes = pad_reg ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
        end

        if (!pos_last)
        begin
            accum_next = {accum_reg[ACC_W-SEXTET_W-1:0], sextet};
            pos_next   = pos_reg + 2'd1;
            pad_next   = pad_reg | (is_pad && pos_reg == 2'd2);
        end
        else
        begin
            accum_next = '0;
            pos_next   = 2'd0;
            pad_next   = 1'b0;
        end

        grp.status = STATUS_OK;
        if (final_char)
        begin
            if (!pos_last)
            begin
                grp.status = STATUS_BAD_LEN;
            end
            else if (err_next)
            begin
                grp.status = STATUS_BAD_CHAR;
            end
        end

        grp.fin = final_char;
        if (nbytes != 2'd0)
        begin
            grp.count      = nbytes;
            grp.byte_valid = 1'b1;
            grp.data       = {accum_reg, sextet};
        end
        else
        begin
            grp.count      = final_char ? 2'd1 : 2'd0;
            grp.byte_valid = 1'b0;
            grp.data       = '0;
        end
        grp.emit = (grp.count != 2'd0);

        // Return to the reset state after the last character of a string
        if (final_char)
        begin
            accum_next = '0;
            pos_next   = 2'd0;
            pad_next   = 1'b0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            pos_reg   <= 2'd0;
            pad_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            accum_reg <= accum_next;
            pos_reg   <= pos_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ hw/rtl/base64_stream_decoder_top.sv @@
// ============================================================================
// base64_stream_decoder_top: streaming base64 decoder
// One character per request in, one decoded byte per request out.
// ============================================================================
// Decodes the standard base64 alphabet (A-Z a-z 0-9 + /, '=' padding) one
// character per input request, with s_tlast on the last character of a string.
// Every fourth character releases 3 bytes (2 or 1 for a final quartet ending
// in "=" or "=="), most significant first, one byte per output request. A
// character outside the alphabet, a code of 128 and above, or a misplaced '='
// sets a sticky error; no further bytes are released for that string, but
// bytes already sent stand. The last output request of a string carries
// stream_done and the status (ok, bad length, bad character; bad length wins).
// A final character with no byte to send yields one request with m_tuser low.
// Timing: a character is taken every cycle except when the input stalls as
// below. The accepting edge loads the group register, and the output
// register, which drives m_tvalid, is loaded from it once the output side is
// free. While m_tready stays high the output side drains one byte per cycle, so a
// full quartet (3 bytes per 4 characters) streams at one character per cycle.
// Input stalls only when a quartet-closing or final character arrives while the
// group register still holds bytes that the output side has not yet taken.
// ============================================================================
module base64_stream_decoder_top
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // final_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [8] stream_done, [10:9] status, rest 0
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast    // run_last
);

    b64d_grp_t           q_grp;
    logic                pos_last;
    logic                in_accept;

    // Group register: results of one character, not yet moved to the output
    logic [1:0]          grp_cnt_reg;
    logic [GROUP_W-1:0]  grp_data_reg;
    logic                grp_bv_reg;
    logic                grp_fin_reg;
    status_t             grp_status_reg;

    // Output register
    logic                m_valid_reg;
    logic [BYTE_W-1:0]   m_data_reg;
    logic                m_bv_reg;
    logic                m_last_reg;
    logic                m_done_reg;
    status_t             m_status_reg;

    logic                out_load;
    logic                grp_free_next;

    assign out_load      = (grp_cnt_reg != 2'd0) && (!m_valid_reg || m_tready);
    assign grp_free_next = (grp_cnt_reg == 2'd0) || (grp_cnt_reg == 2'd1 && out_load);

    // Take a character that neither closes a quartet nor ends a string at any time;
    // hold one that does until the group register is free
    assign s_tready  = grp_free_next || (!pos_last && !s_tlast);
    assign in_accept = s_tvalid && s_tready;

    b64d_quartet u_quartet (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .char_code  (s_tdata),
        .final_char (s_tlast),
        .pos_last   (pos_last),
        .grp        (q_grp)
    );

    // Load a fresh group, or advance to the next byte as one moves out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_cnt_reg <= 2'd0;
        end
        else if (in_accept && q_grp.emit)
        begin
            grp_cnt_reg <= q_grp.count;
        end
        else if (out_load)
        begin
            grp_cnt_reg <= grp_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && q_grp.emit)
        begin
            grp_data_reg   <= q_grp.data;
            grp_bv_reg     <= q_grp.byte_valid;
            grp_fin_reg    <= q_grp.fin;
            grp_status_reg <= q_grp.status;
        end
        else if (out_load)
        begin
            grp_data_reg <= {grp_data_reg[GROUP_W-BYTE_W-1:0], BYTE_W'(0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Mark the last byte of the group; only it carries done and status
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg   <= grp_data_reg[GROUP_W-1 -: BYTE_W];
            m_bv_reg     <= grp_bv_reg;
            m_last_reg   <= (grp_cnt_reg == 2'd1);
            m_done_reg   <= (grp_cnt_reg == 2'd1) && grp_fin_reg;
            m_status_reg <= (grp_cnt_reg == 2'd1) ? grp_status_reg : STATUS_OK;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_status_reg, m_done_reg, m_data_reg};
    assign m_tuser  = m_bv_reg;
    assign m_tlast  = m_last_reg;

    // A character that yields results is only taken when the group register frees up
    a_grp_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && q_grp.emit) |-> grp_free_next)
        else $error("group register overwritten while holding bytes");

    // End of string always closes a run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_done_reg) |-> m_last_reg)
        else $error("stream_done without run_last");

    // A request without a byte only ever closes a string
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_bv_reg) |-> (m_done_reg && m_last_reg))
        else $error("empty result outside end of string");

endmodule
